// ----- rtl/abpf_pkg.sv -----
package abpf_pkg;

  localparam logic [1:0] FMT_BGRX   = 2'd0;
  localparam logic [1:0] FMT_RGB565 = 2'd1;
  localparam logic [1:0] FMT_GRAY   = 2'd2;

  localparam logic [7:0]  CHAN_MAX   = 8'd255;
  localparam logic [15:0] MIX_ROUND  = 16'd127;
  // x/255 for x < 65536: (x * 32897) >> 23
  localparam logic [15:0] DIV255_MUL = 16'd32897;
  localparam int unsigned DIV255_SHR = 23;
  localparam logic [7:0]  ALPHA_BYTE = 8'hFF;
  localparam logic [6:0]  LUMA_R     = 7'd30;
  localparam logic [6:0]  LUMA_G     = 7'd59;
  localparam logic [6:0]  LUMA_B     = 7'd11;
  // y/100 for y <= 25500: (y * 5243) >> 19
  localparam logic [12:0] DIV100_MUL = 13'd5243;
  localparam int unsigned DIV100_SHR = 19;

  // 5-bit widen: (v*255+15)/31 = 8v + (7v+15)/31, x/31 for x <= 232 as (x*265) >> 13
  localparam logic [7:0]  EXP5_ROUND = 8'd15;
  localparam logic [8:0]  EXP5_MUL   = 9'd265;
  localparam int unsigned EXP5_SHR   = 13;
  // 6-bit widen: (v*255+31)/63 = 4v + (3v+31)/63, x/63 for x <= 220 as (x*261) >> 14
  localparam logic [7:0]  EXP6_ROUND = 8'd31;
  localparam logic [8:0]  EXP6_MUL   = 9'd261;
  localparam int unsigned EXP6_SHR   = 14;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] fmt;
  } ctl_t;

  // (v*255+15)/31; the fraction is at most 7, so it fills the low three bits
  function automatic logic [7:0] expand5(input logic [4:0] v);
    logic [7:0]  frac;
    logic [15:0] q;
    frac = {v, 3'b000} - {3'b000, v} + EXP5_ROUND;
    q    = {8'd0, frac} * {7'd0, EXP5_MUL};
    return {v, q[EXP5_SHR +: 3]};
  endfunction

  // (v*255+31)/63; the fraction is at most 3, so it fills the low two bits
  function automatic logic [7:0] expand6(input logic [5:0] v);
    logic [7:0]  frac;
    logic [15:0] q;
    frac = {1'b0, v, 1'b0} + {2'b00, v} + EXP6_ROUND;
    q    = {8'd0, frac} * {7'd0, EXP6_MUL};
    return {v, q[EXP6_SHR +: 2]};
  endfunction

endpackage

// ----- rtl/abpf_decode.sv -----
module abpf_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [1:0]        fmt,
  input  logic [31:0]       dest_pixel,
  input  abpf_pkg::rgb_t    src_in,
  input  logic [7:0]        alpha_in,
  output abpf_pkg::ctl_t    ctl,
  output abpf_pkg::rgb_t    dst,
  output abpf_pkg::rgb_t    src,
  output logic [7:0]        alpha
);

  abpf_pkg::rgb_t dst_next;

  always_comb begin
    case (fmt)
      abpf_pkg::FMT_BGRX: begin
        dst_next.r = dest_pixel[23:16];
        dst_next.g = dest_pixel[15:8];
        dst_next.b = dest_pixel[7:0];
      end
      abpf_pkg::FMT_RGB565: begin
        dst_next.r = abpf_pkg::expand5(dest_pixel[15:11]);
        dst_next.g = abpf_pkg::expand6(dest_pixel[10:5]);
        dst_next.b = abpf_pkg::expand5(dest_pixel[4:0]);
      end
      default: begin
        // gray and the unused code: byte to all channels
        dst_next.r = dest_pixel[7:0];
        dst_next.g = dest_pixel[7:0];
        dst_next.b = dest_pixel[7:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= in_valid;
    end
    ctl.fmt <= fmt;
    dst     <= dst_next;
    src     <= src_in;
    alpha   <= alpha_in;
  end

endmodule

// ----- rtl/abpf_mix.sv -----
module abpf_mix (
  input  logic              clk,
  input  logic              rst,
  input  abpf_pkg::ctl_t    ctl_in,
  input  abpf_pkg::rgb_t    dst,
  input  abpf_pkg::rgb_t    src,
  input  logic [7:0]        alpha,
  output abpf_pkg::ctl_t    ctl,
  output abpf_pkg::rgb_t    mixed
);

  abpf_pkg::ctl_t ctl_mid;
  logic [15:0]    sum_r, sum_g, sum_b;
  logic [15:0]    sum_r_next, sum_g_next, sum_b_next;
  logic [7:0]     inv_alpha;
  logic [31:0]    prod_r, prod_g, prod_b;

  assign inv_alpha = abpf_pkg::CHAN_MAX - alpha;

  // max 255*255 + 127 fits in 16 bits
  assign sum_r_next = 16'(src.r * alpha) + 16'(dst.r * inv_alpha) + abpf_pkg::MIX_ROUND;
  assign sum_g_next = 16'(src.g * alpha) + 16'(dst.g * inv_alpha) + abpf_pkg::MIX_ROUND;
  assign sum_b_next = 16'(src.b * alpha) + 16'(dst.b * inv_alpha) + abpf_pkg::MIX_ROUND;

  assign prod_r = sum_r * abpf_pkg::DIV255_MUL;
  assign prod_g = sum_g * abpf_pkg::DIV255_MUL;
  assign prod_b = sum_b * abpf_pkg::DIV255_MUL;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid.valid <= 1'b0;
      ctl.valid     <= 1'b0;
    end else begin
      ctl_mid.valid <= ctl_in.valid;
      ctl.valid     <= ctl_mid.valid;
    end
    ctl_mid.fmt <= ctl_in.fmt;
    sum_r       <= sum_r_next;
    sum_g       <= sum_g_next;
    sum_b       <= sum_b_next;
    ctl.fmt     <= ctl_mid.fmt;
    mixed.r     <= prod_r[abpf_pkg::DIV255_SHR +: 8];
    mixed.g     <= prod_g[abpf_pkg::DIV255_SHR +: 8];
    mixed.b     <= prod_b[abpf_pkg::DIV255_SHR +: 8];
  end

endmodule

// ----- rtl/abpf_encode.sv -----
module abpf_encode (
  input  logic              clk,
  input  logic              rst,
  input  abpf_pkg::ctl_t    ctl_in,
  input  abpf_pkg::rgb_t    mixed,
  output logic              out_valid,
  output logic [31:0]       pixel,
  output abpf_pkg::rgb_t    chan
);

  abpf_pkg::ctl_t ctl_mid;
  abpf_pkg::rgb_t mixed_mid;
  logic [14:0]    luma_sum;
  logic [14:0]    luma_sum_next;
  logic [27:0]    luma_prod;
  logic [31:0]    pixel_next;

  // max 100*255 = 25500
  assign luma_sum_next = 15'(mixed.r * abpf_pkg::LUMA_R)
                       + 15'(mixed.g * abpf_pkg::LUMA_G)
                       + 15'(mixed.b * abpf_pkg::LUMA_B);

  assign luma_prod = luma_sum * abpf_pkg::DIV100_MUL;

  always_comb begin
    case (ctl_mid.fmt)
      abpf_pkg::FMT_BGRX: begin
        pixel_next = {abpf_pkg::ALPHA_BYTE, mixed_mid.r, mixed_mid.g, mixed_mid.b};
      end
      abpf_pkg::FMT_RGB565: begin
        pixel_next = {16'd0, mixed_mid.r[7:3], mixed_mid.g[7:2], mixed_mid.b[7:3]};
      end
      default: begin
        pixel_next = {24'd0, luma_prod[abpf_pkg::DIV100_SHR +: 8]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid.valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      ctl_mid.valid <= ctl_in.valid;
      out_valid     <= ctl_mid.valid;
    end
    ctl_mid.fmt <= ctl_in.fmt;
    mixed_mid   <= mixed;
    luma_sum    <= luma_sum_next;
    pixel       <= pixel_next;
    chan        <= mixed_mid;
  end

endmodule

// ----- rtl/alpha_blend_pixel_formats_top.sv -----
// Throughput: one pixel per cycle; busy is never raised.
// The receiver cannot stall: each result shows for exactly one cycle.
// Reset (rst, synchronous, active high) empties the pipeline and sets
// pixel_format to 32-bit BGRX; results in flight are dropped.
module alpha_blend_pixel_formats_top (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [31:0] dest_pixel,
  input  logic [7:0]  source_red,
  input  logic [7:0]  source_green,
  input  logic [7:0]  source_blue,
  input  logic [7:0]  opacity,
  // result strobe
  output logic        done,
  output logic [31:0] blended_pixel,
  output logic [7:0]  blended_red,
  output logic [7:0]  blended_green,
  output logic [7:0]  blended_blue,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data
);

  logic [1:0]     pixel_format;
  logic           accept;
  abpf_pkg::rgb_t src_in;
  abpf_pkg::ctl_t dec_ctl, mix_ctl;
  abpf_pkg::rgb_t dec_dst, dec_src, mixed, chan;
  logic [7:0]     dec_alpha;

  // Pipeline has no back-pressure, so a command is always taken.
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  // Format register. The format also rides along with each pixel, so
  // results already in flight keep the format they entered with.
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= abpf_pkg::FMT_BGRX;
    end else if (cfg_valid && cfg_ready) begin
      pixel_format <= cfg_data;
    end
  end

  assign src_in.r = source_red;
  assign src_in.g = source_green;
  assign src_in.b = source_blue;

  // Stage 1: unpack destination to 8-bit channels.
  abpf_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .fmt        (pixel_format),
    .dest_pixel (dest_pixel),
    .src_in     (src_in),
    .alpha_in   (opacity),
    .ctl        (dec_ctl),
    .dst        (dec_dst),
    .src        (dec_src),
    .alpha      (dec_alpha)
  );

  // Stages 2-3: weighted sum, then divide by 255 via reciprocal multiply.
  abpf_mix u_mix (
    .clk    (clk),
    .rst    (rst),
    .ctl_in (dec_ctl),
    .dst    (dec_dst),
    .src    (dec_src),
    .alpha  (dec_alpha),
    .ctl    (mix_ctl),
    .mixed  (mixed)
  );

  // Stages 4-5: luma sum, then pack into the output format.
  abpf_encode u_encode (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (mix_ctl),
    .mixed     (mixed),
    .out_valid (done),
    .pixel     (blended_pixel),
    .chan      (chan)
  );

  assign blended_red   = chan.r;
  assign blended_green = chan.g;
  assign blended_blue  = chan.b;

endmodule

// ----- rtl/abpf_checker.sv -----
module abpf_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [31:0] blended_pixel,
  input logic [7:0]  blended_red,
  input logic [7:0]  blended_green,
  input logic [7:0]  blended_blue
);

  // every accepted transaction yields a result at the end of the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##5 done)
    else $error("result missing after accepted transaction");

  // no result without a matching accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without matching transaction");

  // 32-bit format result carries the channels verbatim
  a_bgrx_pack: assert property (@(posedge clk) disable iff (rst)
    (done && blended_pixel[31:24] != 8'd0) |->
      (blended_pixel == {8'hFF, blended_red, blended_green, blended_blue}))
    else $error("BGRX packing mismatch");

  // nothing comes out in the cycle after reset
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result right after reset");

endmodule

bind alpha_blend_pixel_formats_top abpf_checker u_abpf_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .blended_pixel (blended_pixel),
  .blended_red   (blended_red),
  .blended_green (blended_green),
  .blended_blue  (blended_blue)
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  // Selector value 3 has no format of its own; the block treats it as gray.
  localparam logic [1:0] FMT_SPARE = 2'd3;

  // Pipeline is 5 deep; leave a little margin after the last result.
  localparam int unsigned PIPE_DEPTH  = 5;
  localparam int unsigned DRAIN_LIMIT = 200;

  // Pixel rate is one per clock, so even the slowest legal run of 1460
  // items with gaps and format changes ends well within this limit.
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;

  typedef struct packed {
    logic [31:0] pix;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
  } blend_result_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] dest_pixel;
  logic [7:0]  source_red;
  logic [7:0]  source_green;
  logic [7:0]  source_blue;
  logic [7:0]  opacity;
  logic        done;
  logic [31:0] blended_pixel;
  logic [7:0]  blended_red;
  logic [7:0]  blended_green;
  logic [7:0]  blended_blue;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_data;

  // Shadow of the pixel_format register, updated on each accepted write.
  logic [1:0]    cur_format;
  // Blended pixels predicted for accepted transactions, oldest first.
  blend_result_t blend_queue[$];
  int unsigned   error_count;
  // When clear, the sender never inserts gaps between transactions.
  bit            gaps_enabled;

  alpha_blend_pixel_formats_top dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .dest_pixel    (dest_pixel),
    .source_red    (source_red),
    .source_green  (source_green),
    .source_blue   (source_blue),
    .opacity       (opacity),
    .done          (done),
    .blended_pixel (blended_pixel),
    .blended_red   (blended_red),
    .blended_green (blended_green),
    .blended_blue  (blended_blue),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #(RUN_LIMIT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // ------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------

  // Source-over mix of one channel, rounded to nearest.
  function automatic int unsigned mix_chan(input int unsigned s, input int unsigned d,
                                           input int unsigned a);
    return (s * a + d * (abpf_pkg::CHAN_MAX - a) + abpf_pkg::MIX_ROUND) / abpf_pkg::CHAN_MAX;
  endfunction

  function automatic blend_result_t blend_pixel(input logic [1:0] fmt,
                                                input logic [31:0] dp,
                                                input logic [7:0] sr, input logic [7:0] sg,
                                                input logic [7:0] sb, input logic [7:0] a);
    int unsigned   dr, dg, db, r, g, b, luma;
    blend_result_t res;
    // decode the destination into 8-bit channels
    case (fmt)
      abpf_pkg::FMT_BGRX: begin
        db = 32'(dp[7:0]);
        dg = 32'(dp[15:8]);
        dr = 32'(dp[23:16]);
      end
      abpf_pkg::FMT_RGB565: begin
        // 5/6-bit fields widened with rounding
        dr = (int'(dp[15:11]) * 255 + 15) / 31;
        dg = (int'(dp[10:5]) * 255 + 31) / 63;
        db = (int'(dp[4:0]) * 255 + 15) / 31;
      end
      default: begin
        // gray, and the unused selector: byte copied to every channel
        dr = 32'(dp[7:0]);
        dg = dr;
        db = dr;
      end
    endcase
    r = mix_chan(32'(sr), dr, 32'(a));
    g = mix_chan(32'(sg), dg, 32'(a));
    b = mix_chan(32'(sb), db, 32'(a));
    res.r = r[7:0];
    res.g = g[7:0];
    res.b = b[7:0];
    // re-encode in the same format
    case (fmt)
      abpf_pkg::FMT_BGRX:   res.pix = {abpf_pkg::ALPHA_BYTE, res.r, res.g, res.b};
      abpf_pkg::FMT_RGB565: res.pix = {16'd0, res.r[7:3], res.g[7:2], res.b[7:3]};
      default: begin
        luma = (abpf_pkg::LUMA_R * r + abpf_pkg::LUMA_G * g + abpf_pkg::LUMA_B * b) / 100;
        res.pix = {24'd0, luma[7:0]};
      end
    endcase
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Checking
  // ------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: %s: got 0x%08h, expected 0x%08h", $realtime, what, got, want);
    error_count++;
  endtask

  // Results show for one cycle only; sample done as it stood before the edge.
  always @(posedge clk) begin
    blend_result_t want;
    if (!rst && done) begin
      if (blend_queue.size() == 0) begin
        report_mismatch("result with no transaction pending", blended_pixel, 32'd0);
      end else begin
        want = blend_queue.pop_front();
        if (blended_pixel !== want.pix)
          report_mismatch("blended_pixel", blended_pixel, want.pix);
        if (blended_red !== want.r)
          report_mismatch("blended_red", {24'd0, blended_red}, {24'd0, want.r});
        if (blended_green !== want.g)
          report_mismatch("blended_green", {24'd0, blended_green}, {24'd0, want.g});
        if (blended_blue !== want.b)
          report_mismatch("blended_blue", {24'd0, blended_blue}, {24'd0, want.b});
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------

  // Random idle gap before a transaction now and then, otherwise back to back.
  function automatic int unsigned pick_gap();
    if (!gaps_enabled) return 0;
    if ($urandom_range(0, 3) != 0) return 0;
    return $urandom_range(1, 7);
  endfunction

  // Channel values lean toward the extremes where rounding is tight.
  function automatic logic [7:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'($urandom_range(0, 3));
      3:       return 8'($urandom_range(252, 255));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Called at a falling edge. Leaves start high so a following call can
  // stream without a bubble; stop_stream() drops it.
  task automatic send_pixel(input logic [31:0] dp, input logic [7:0] sr,
                            input logic [7:0] sg, input logic [7:0] sb,
                            input logic [7:0] a);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    dest_pixel   = dp;
    source_red   = sr;
    source_green = sg;
    source_blue  = sb;
    opacity      = a;
    start        = 1'b1;
    do @(posedge clk); while (busy);
    blend_queue.push_back(blend_pixel(cur_format, dp, sr, sg, sb, a));
    @(negedge clk);
  endtask

  task automatic stop_stream();
    start = 1'b0;
  endtask

  task automatic send_random_pixel();
    logic [31:0] dp;
    logic [7:0]  a;
    dp = $urandom;
    case ($urandom_range(0, 9))
      0: dp = 32'h0000_0000;
      1: dp = 32'hFFFF_FFFF;
      2: dp = {dp[31:8], rand_chan()};
      default: ;
    endcase
    a = rand_chan();
    send_pixel(dp, rand_chan(), rand_chan(), rand_chan(), a);
  endtask

  // Register write; only done with no transaction in flight.
  task automatic set_format(input logic [1:0] fmt);
    stop_stream();
    while (blend_queue.size() != 0) @(negedge clk);
    if (gaps_enabled) repeat ($urandom_range(0, 3)) @(negedge clk);
    cfg_data  = fmt;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cur_format = fmt;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = 2'd0;
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Straight out of reset the block must be in 32-bit BGRX.
  task automatic test_reset_format();
    send_pixel(32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // transparent source: destination passes through, top byte ignored
    send_pixel(32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(32'h0000_0000, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(32'h1234_5678, 8'h9A, 8'hBC, 8'hDE, 8'h80);
    send_pixel(32'hAA55_AA55, 8'h55, 8'hAA, 8'h01, 8'h01);
    send_pixel(32'h00FE_01FF, 8'h01, 8'hFE, 8'h00, 8'hFE);
    stop_stream();
  endtask

  task automatic test_rgb565_decode();
    set_format(abpf_pkg::FMT_RGB565);
    send_pixel(32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
    // full-scale fields widen to 255
    send_pixel(32'h0000_FFFF, 8'h00, 8'h00, 8'h00, 8'h00);
    // upper half ignored
    send_pixel(32'hFFFF_0000, 8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_pixel(32'h0000_F800, 8'h00, 8'hFF, 8'h00, 8'h40);
    send_pixel(32'h0000_07E0, 8'hFF, 8'h00, 8'hFF, 8'hFF);
    send_pixel(32'h5A5A_001F, 8'h80, 8'h40, 8'h20, 8'h7F);
    stop_stream();
  endtask

  task automatic test_gray_decode();
    set_format(abpf_pkg::FMT_GRAY);
    send_pixel(32'h0000_00FF, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(32'hFFFF_FF00, 8'h00, 8'h00, 8'h00, 8'h00);
    // single-channel sources show the luma weights
    send_pixel(32'h0000_0080, 8'hFF, 8'h00, 8'h00, 8'hFF);
    send_pixel(32'h0000_0000, 8'h00, 8'hFF, 8'h00, 8'hFF);
    send_pixel(32'h0000_003C, 8'h00, 8'h00, 8'hFF, 8'hC8);
    stop_stream();
  endtask

  // Unused selector must behave like gray.
  task automatic test_spare_format();
    set_format(FMT_SPARE);
    send_pixel(32'h1234_5680, 8'hFF, 8'hFF, 8'hFF, 8'h80);
    send_pixel(32'hFFFF_FFFF, 8'h10, 8'h20, 8'h30, 8'h00);
    stop_stream();
  endtask

  // Bulk of the run: segments of random pixels, format changed between them.
  task automatic test_random_blend(input int unsigned n_items);
    logic [1:0]  fmt;
    int unsigned sent, seg, seg_len;
    sent = 0;
    seg  = 0;
    while (sent < n_items) begin
      // walk every selector first, then pick at random
      fmt = (seg < 4) ? 2'(seg) : 2'($urandom_range(0, 3));
      set_format(fmt);
      // two stretches with gaps, then one without
      gaps_enabled = (seg % 3) != 2;
      seg_len = $urandom_range(60, 220);
      for (int unsigned i = 0; i < seg_len && sent < n_items; i++) begin
        send_random_pixel();
        sent++;
      end
      stop_stream();
      seg++;
    end
    gaps_enabled = 1'b1;
  endtask

  // Tail of the run: full rate, no gaps, each real format once.
  task automatic test_full_rate(input int unsigned per_format);
    gaps_enabled = 1'b0;
    for (int f = 0; f < 3; f++) begin
      set_format(2'(f));
      repeat (per_format) send_random_pixel();
      stop_stream();
    end
  endtask

  task automatic drain_results();
    int unsigned waited;
    blend_result_t left;
    stop_stream();
    waited = 0;
    while (blend_queue.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (PIPE_DEPTH + 3) @(negedge clk);
    while (blend_queue.size() != 0) begin
      left = blend_queue.pop_front();
      report_mismatch("result never arrived", 32'd0, left.pix);
    end
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    dest_pixel   = 32'd0;
    source_red   = 8'd0;
    source_green = 8'd0;
    source_blue  = 8'd0;
    opacity      = 8'd0;
    cfg_valid    = 1'b0;
    cfg_data     = 2'd0;
    cur_format   = abpf_pkg::FMT_BGRX;
    error_count  = 0;
    gaps_enabled = 1'b1;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_format();
    test_rgb565_decode();
    test_gray_decode();
    test_spare_format();
    test_random_blend(1230);
    test_full_rate(70);
    drain_results();

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
